// ===== hw/rtl/ldf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared constants and types of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

	// frame header layout
	localparam logic [2:0] HDR_LEN    = 3'd6;   // header bytes per frame
	localparam logic [2:0] HDR_LAST   = 3'd5;   // slot of the length high byte
	localparam int         BYTE_SHIFT = 8;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_HDR_ONLY = 2'd1;
	localparam logic [1:0] KIND_OVERSIZE = 2'd2;

	// configuration port
	localparam int          ADDR_W       = 3;
	localparam int          DATA_W       = 32;
	localparam logic        REG_MAX_LEN  = 1'b0;   // register index of max_payload_len
	localparam logic [15:0] MAX_LEN_RST  = 16'd1024;

	// one result beat
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  msg_type;
		logic [7:0]  arg_a;
		logic [7:0]  arg_b;
		logic [7:0]  arg_c;
		logic [15:0] payload_len;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        last_in_frame;
	} ldf_result_t;

endpackage : ldf_pkg
`default_nettype wire

// ===== hw/rtl/ldf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_cfg
// APB-style register file holding the maximum accepted payload length.
// ----------------------------------------------------------------------------
module ldf_cfg
	import ldf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output logic      [15:0]       max_len
);

	logic [15:0] max_len_q;
	logic        reg_idx;
	logic        wr_en;

	// registers sit on 4-byte boundaries
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (wr_en && (reg_idx == REG_MAX_LEN)) begin
			max_len_q <= pwdata[15:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MAX_LEN) begin
			prdata = {{(DATA_W-16){1'b0}}, max_len_q};
		end
	end

	assign max_len = max_len_q;

endmodule : ldf_cfg
`default_nettype wire

// ===== hw/rtl/ldf_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_parse
// Input register and frame parser: header capture, length check, payload
// tagging and the sticky error flag.
// ----------------------------------------------------------------------------
module ldf_parse
	import ldf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] max_len,
	input  wire logic        out_ready,
	output logic             res_valid,
	output ldf_result_t      res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic [7:0]  hs_q [HDR_LEN];
	logic [2:0]  hc_q;
	logic [15:0] pc_q;
	logic        err_q;

	logic        has_res;
	logic        adv;
	logic        accept;
	logic [2:0]  hc_d;
	logic [15:0] pc_d;
	logic        err_d;
	logic        hs_wr;
	logic [15:0] frame_len;
	logic [15:0] hdr_len;
	logic [16:0] idx_inc;

	assign accept   = in_valid && !in_stall;
	assign adv      = valid_s1 && (!has_res || out_ready);
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

	// length as stored, and as it reads once the current byte lands in slot 5
	assign frame_len = {hs_q[HDR_LAST], hs_q[4]};
	assign hdr_len   = {byte_s1, hs_q[4]};
	assign idx_inc   = {1'b0, pc_q} + 17'd1;

	// per-beat decode
	always_comb begin
		has_res = 1'b0;
		hs_wr   = 1'b0;
		hc_d    = hc_q;
		pc_d    = pc_q;
		err_d   = err_q;
		res     = '0;
		res.msg_type = hs_q[0];
		res.arg_a    = hs_q[1];
		res.arg_b    = hs_q[2];
		res.arg_c    = hs_q[3];
		res.payload_len = frame_len;
		if (err_q) begin
			// dropped
		end else if (hc_q < HDR_LEN) begin
			hs_wr = 1'b1;
			hc_d  = hc_q + 3'd1;
			if (hc_q == HDR_LAST) begin
				pc_d = '0;
				res.payload_len   = hdr_len;
				res.last_in_frame = 1'b1;
				if (hdr_len > max_len) begin
					has_res  = 1'b1;
					err_d    = 1'b1;
					res.kind = KIND_OVERSIZE;
				end else if (hdr_len == 16'd0) begin
					has_res  = 1'b1;
					hc_d     = '0;
					res.kind = KIND_HDR_ONLY;
				end
			end
		end else begin
			// payload beat
			has_res           = 1'b1;
			res.kind          = KIND_PAYLOAD;
			res.payload_byte  = byte_s1;
			res.byte_index    = pc_q;
			res.last_in_frame = idx_inc >= {1'b0, frame_len};
			if (res.last_in_frame) begin
				hc_d = '0;
				pc_d = '0;
			end else begin
				pc_d = idx_inc[15:0];
			end
		end
	end

	assign res_valid = adv && has_res;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q  <= '0;
			pc_q  <= '0;
			err_q <= 1'b0;
			for (int i = 0; i < HDR_LEN; i++) begin
				hs_q[i] <= '0;
			end
		end else if (adv) begin
			hc_q  <= hc_d;
			pc_q  <= pc_d;
			err_q <= err_d;
			if (hs_wr) begin
				hs_q[hc_q] <= byte_s1;
			end
		end
	end

	// the error flag is sticky
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared without reset");

	// header count never passes the header length
	a_hc_range: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q <= HDR_LEN)
		else $error("header count out of range");

	// payload bytes are counted only in the payload phase
	a_pc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != 16'd0) |-> (hc_q == HDR_LEN))
		else $error("payload count set outside payload phase");

	// an oversize result latches the error
	a_err_set: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.kind == KIND_OVERSIZE)) |=> err_q)
		else $error("oversize result without error latch");

endmodule : ldf_parse
`default_nettype wire

// ===== hw/rtl/ldf_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_out
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ldf_out
	import ldf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        res_valid,
	input  wire ldf_result_t res,
	output logic             out_ready,
	output logic             out_valid,
	input  wire logic        out_stall,
	output ldf_result_t      out_data
);

	logic        valid_q;
	ldf_result_t data_q;

	// free when empty or draining this cycle
	assign out_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule : ldf_out
`default_nettype wire

// ===== hw/rtl/length_prefixed_frame_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core
// Byte-stream deframer for frames of a six-byte header plus payload.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and accepts a new byte every cycle while
// the result sink keeps up; a byte is registered on entry and its result, if
// any, is loaded into the result register once that register is free, which
// raises out_valid. Header bytes other than the sixth give no result. A
// zero-length header gives a single header-only result, a length above
// max_payload_len gives one error result and then all later bytes are
// dropped until reset. Each payload byte comes out tagged with the header
// fields, its index and a last marker. Backpressure from out_stall reaches
// in_stall in the same cycle only for bytes that produce a result.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_core
	import ldf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// input bytes
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        data_byte,
	// results
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [1:0]        kind,
	output logic      [7:0]        msg_type,
	output logic      [7:0]        arg_a,
	output logic      [7:0]        arg_b,
	output logic      [7:0]        arg_c,
	output logic      [15:0]       payload_len,
	output logic      [7:0]        payload_byte,
	output logic      [15:0]       byte_index,
	output logic                   last_in_frame
);

	logic [15:0] max_len;
	logic        out_ready;
	logic        res_valid;
	ldf_result_t res;
	ldf_result_t out_data;

	ldf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_len (max_len)
	);

	ldf_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.max_len   (max_len),
		.out_ready (out_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	ldf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind          = out_data.kind;
	assign msg_type      = out_data.msg_type;
	assign arg_a         = out_data.arg_a;
	assign arg_b         = out_data.arg_b;
	assign arg_c         = out_data.arg_c;
	assign payload_len   = out_data.payload_len;
	assign payload_byte  = out_data.payload_byte;
	assign byte_index    = out_data.byte_index;
	assign last_in_frame = out_data.last_in_frame;

endmodule : length_prefixed_frame_deframer_core
`default_nettype wire

// ===== tb/sv/ldf_frame_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_frame_scoreboard_pkg
// Frame-level predictor and result checker for the deframer testbench.
// ----------------------------------------------------------------------------
// Each accepted stream byte is run through a behavioral deframer that keeps
// its own header, payload index, error flag and length limit. Any beat it
// predicts is queued. Each beat taken from the block is checked, field by
// field, against the oldest queued beat.
// ----------------------------------------------------------------------------
package ldf_frame_scoreboard_pkg;
	import ldf_pkg::*;

	localparam int HDR_BYTES   = HDR_LEN;
	localparam int MAX_REPORTS = 10;

	class frame_scoreboard;
		logic [7:0]  hdr_bytes [HDR_BYTES];
		int          hdr_fill;
		logic [15:0] pay_idx;
		bit          halted;
		logic [15:0] len_limit;
		ldf_result_t due_beats [$];

		int unsigned mismatches;
		int unsigned bytes_in;
		int unsigned payload_beats;
		int unsigned hdr_only_beats;
		int unsigned oversize_beats;

		function new();
			foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
			hdr_fill       = 0;
			pay_idx        = 16'd0;
			halted         = 1'b0;
			len_limit      = MAX_LEN_RST;
			mismatches     = 0;
			bytes_in       = 0;
			payload_beats  = 0;
			hdr_only_beats = 0;
			oversize_beats = 0;
		endfunction

		function void set_len_limit(logic [15:0] value);
			len_limit = value;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		// beat carrying the current header fields
		function ldf_result_t tag_beat(logic [1:0] k, logic [7:0] pbyte,
				logic [15:0] idx, logic last);
			ldf_result_t r;
			r.kind          = k;
			r.msg_type      = hdr_bytes[0];
			r.arg_a         = hdr_bytes[1];
			r.arg_b         = hdr_bytes[2];
			r.arg_c         = hdr_bytes[3];
			r.payload_len   = {hdr_bytes[5], hdr_bytes[4]};
			r.payload_byte  = pbyte;
			r.byte_index    = idx;
			r.last_in_frame = last;
			return r;
		endfunction

		// predict the effect of one accepted stream byte
		function void deframe_byte(logic [7:0] b);
			logic [15:0] len;
			logic        last;
			bytes_in++;
			if (halted)
				return;
			// header collection
			if (hdr_fill < HDR_BYTES) begin
				hdr_bytes[hdr_fill] = b;
				hdr_fill++;
				if (hdr_fill < HDR_BYTES)
					return;
				len     = {hdr_bytes[5], hdr_bytes[4]};
				pay_idx = 16'd0;
				if (len > len_limit) begin
					halted = 1'b1;
					due_beats.push_back(tag_beat(KIND_OVERSIZE, 8'h00, 16'd0, 1'b1));
				end else if (len == 16'd0) begin
					hdr_fill = 0;
					due_beats.push_back(tag_beat(KIND_HDR_ONLY, 8'h00, 16'd0, 1'b1));
				end
				return;
			end
			// payload byte
			len  = {hdr_bytes[5], hdr_bytes[4]};
			last = ({1'b0, pay_idx} + 17'd1) >= {1'b0, len};
			due_beats.push_back(tag_beat(KIND_PAYLOAD, b, pay_idx, last));
			if (last) begin
				hdr_fill = 0;
				pay_idx  = 16'd0;
			end else begin
				pay_idx = pay_idx + 16'd1;
			end
		endfunction

		function void flag(string what, ldf_result_t want, ldf_result_t got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%s: want kind=%0d type=%02h a=%02h b=%02h c=%02h len=%0d byte=%02h idx=%0d last=%0b | got kind=%0d type=%02h a=%02h b=%02h c=%02h len=%0d byte=%02h idx=%0d last=%0b",
					what, want.kind, want.msg_type, want.arg_a, want.arg_b, want.arg_c,
					want.payload_len, want.payload_byte, want.byte_index, want.last_in_frame,
					got.kind, got.msg_type, got.arg_a, got.arg_b, got.arg_c,
					got.payload_len, got.payload_byte, got.byte_index, got.last_in_frame);
		endfunction

		// compare one beat from the block with the oldest prediction
		function void check_beat(ldf_result_t got);
			ldf_result_t want;
			if (due_beats.size() == 0) begin
				flag("beat with nothing due", '0, got);
				return;
			end
			want = due_beats.pop_front();
			case (want.kind)
				KIND_PAYLOAD:  payload_beats++;
				KIND_HDR_ONLY: hdr_only_beats++;
				default:       oversize_beats++;
			endcase
			if (got.kind !== want.kind || got.msg_type !== want.msg_type ||
					got.arg_a !== want.arg_a || got.arg_b !== want.arg_b ||
					got.arg_c !== want.arg_c || got.payload_len !== want.payload_len ||
					got.payload_byte !== want.payload_byte ||
					got.byte_index !== want.byte_index ||
					got.last_in_frame !== want.last_in_frame)
				flag("beat mismatch", want, got);
		endfunction
	endclass

endpackage : ldf_frame_scoreboard_pkg

// ===== tb/sv/length_prefixed_frame_deframer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core_test
// Self-checking testbench of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// Feeds whole frames through the byte port in random bursts while the result
// side stalls in changing patterns. A short directed run covers header-only
// frames, limit changes inside a header and inside a payload, and a write to
// an unmapped register. Random phases then sweep the length limit from 0 to
// 65535, and the run ends with an oversize header followed by bytes that must
// be dropped. Every result beat is checked by the frame scoreboard.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_core_test;
	import ldf_pkg::*;
	import ldf_frame_scoreboard_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 4;    // margin for bytes still in flight
	localparam int TAIL_CYCLES  = 10;
	localparam int STUCK_LIMIT  = 2000;
	localparam int PHASE_BYTES  = 110;

	localparam logic              REG_UNUSED   = 1'b1;
	localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_UNUSED  = {REG_UNUSED, 2'b00};

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        kind;
	logic [7:0]        msg_type;
	logic [7:0]        arg_a;
	logic [7:0]        arg_b;
	logic [7:0]        arg_c;
	logic [15:0]       payload_len;
	logic [7:0]        payload_byte;
	logic [15:0]       byte_index;
	logic              last_in_frame;

	ldf_result_t       seen_beat;
	frame_scoreboard   sb;
	logic [7:0]        tx_bytes [$];
	int unsigned       reg_writes;
	int                stuck_cycles;
	stall_mode_e       stall_mode;
	int                stall_left;
	int unsigned       stall_tick;

	length_prefixed_frame_deframer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.msg_type      (msg_type),
		.arg_a         (arg_a),
		.arg_b         (arg_b),
		.arg_c         (arg_c),
		.payload_len   (payload_len),
		.payload_byte  (payload_byte),
		.byte_index    (byte_index),
		.last_in_frame (last_in_frame)
	);

	assign seen_beat = {kind, msg_type, arg_a, arg_b, arg_c, payload_len,
		payload_byte, byte_index, last_in_frame};

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// beat monitor: results first, they belong to earlier bytes
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_beat(seen_beat);
			if (in_valid && !in_stall)
				sb.deframe_byte(data_byte);
		end
	end

	// result-side stall pattern, mode picked at random for each run
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_PERIODIC));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
			default:        out_stall <= (stall_tick % 4 == 0);
		endcase
	end

	// watchdog on cycles without any accepted beat or register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("length_prefixed_frame_deframer_core_test NOT OK");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// header only, length sent low byte first
	task automatic queue_header(logic [7:0] t, logic [7:0] a, logic [7:0] b,
			logic [7:0] c, logic [15:0] len);
		tx_bytes.push_back(t);
		tx_bytes.push_back(a);
		tx_bytes.push_back(b);
		tx_bytes.push_back(c);
		tx_bytes.push_back(len[7:0]);
		tx_bytes.push_back(len[15:8]);
	endtask

	task automatic queue_frame(logic [7:0] t, logic [7:0] a, logic [7:0] b,
			logic [7:0] c, logic [15:0] len);
		queue_header(t, a, b, c, len);
		repeat (len) tx_bytes.push_back(8'($urandom));
	endtask

	task automatic queue_random_frame(logic [15:0] len);
		queue_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), len);
	endtask

	// mostly short payloads, some zero, some at the limit
	function automatic logic [15:0] pick_len(logic [15:0] limit);
		int r;
		int cap;
		r = $urandom_range(0, 19);
		if (limit == 16'd0 || r < 3)
			return 16'd0;
		if (r == 18 && limit <= 16'd300)
			return limit;
		cap = (r == 19) ? 300 : 20;
		if (cap > limit)
			cap = limit;
		return 16'($urandom_range(1, cap));
	endfunction

	// send n queued bytes in bursts with random gaps, valid low at the end
	task automatic send_bytes(int n);
		int burst;
		int gap;
		burst = 0;
		while (n > 0 && tx_bytes.size() > 0) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			in_valid  <= 1'b1;
			data_byte <= tx_bytes.pop_front();
			burst--;
			n--;
			do @(posedge clk); while (!(in_valid && !in_stall));
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_all();
		send_bytes(tx_bytes.size());
	endtask

	// all due beats out, then wait out DRAIN_CYCLES for bytes still in flight
	task automatic wait_idle();
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_MAX_LEN)
			sb.set_len_limit(value[15:0]);
		reg_writes++;
	endtask

	// upper bits are random, only the low 16 count
	task automatic set_limit(logic [15:0] limit);
		wait_idle();
		apb_write(ADDR_MAX_LEN, {16'($urandom), limit});
	endtask

	initial begin
		logic [15:0] limits [7];
		logic [15:0] limit;
		sb           = new();
		stall_mode   = STALL_NONE;
		stall_left   = 0;
		stall_tick   = 0;
		stuck_cycles = 0;
		reg_writes   = 0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		data_byte    = 8'h00;
		out_stall    = 1'b0;
		limits       = '{16'hFFFF, 16'd16, MAX_LEN_RST, 16'd0, 16'd1, 16'd300, 16'd0};
		limits[6]    = 16'($urandom_range(2, 64));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header-only frame and a one-byte frame under the reset limit
		queue_frame(8'hFF, 8'h00, 8'hFF, 8'hAA, 16'd0);
		queue_frame(8'h00, 8'hFF, 8'h55, 8'hAA, 16'd1);
		send_all();
		// limit dropped to zero inside an accepted payload
		queue_frame(8'h5A, 8'hA5, 8'h0F, 8'hF0, 16'd2);
		send_bytes(7);
		set_limit(16'd0);
		send_all();
		// limit raised inside a header, checked only when it completes
		queue_frame(8'h80, 8'h7F, 8'h01, 8'hFE, 16'd2);
		send_bytes(3);
		set_limit(16'hFFFF);
		send_all();
		// unmapped register, must leave the limit alone
		wait_idle();
		apb_write(ADDR_UNUSED, '0);

		// random phases over a sweep of limits
		foreach (limits[p]) begin
			limit = limits[p];
			set_limit(limit);
			if (limit == 16'hFFFF)
				queue_random_frame(16'($urandom_range(256, 300)));
			while (tx_bytes.size() < PHASE_BYTES)
				queue_random_frame(pick_len(limit));
			send_all();
		end

		// oversize by one, then bytes that must be dropped
		set_limit(16'hFFFE);
		queue_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'hFFFF);
		repeat (24) tx_bytes.push_back(8'($urandom));
		send_all();

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d stream bytes and %0d register writes over limits 0..65535",
			sb.bytes_in, reg_writes);
		$display("beats checked: %0d payload, %0d header-only, %0d oversize; %0d mismatches",
			sb.payload_beats, sb.hdr_only_beats, sb.oversize_beats, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("length_prefixed_frame_deframer_core_test OK");
		end else begin
			$display("length_prefixed_frame_deframer_core_test NOT OK");
		end
		$finish;
	end

endmodule : length_prefixed_frame_deframer_core_test
